// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define SOSP_ASSERT_IMPLY(label, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define SOSP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== design/sosp_pkg.sv =====
// Types, codes and sizes shared by the shuffle-or-sequential picker.
package sosp_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ID_BITS     = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int RAND_W      = 30;
  localparam int PROD_W      = CNT_W + RAND_W;
  localparam int STATUS_W    = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RANDOM_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MODE  = 1'b1;

  // Input mode codes
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_NEXT   = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SERVED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd3;

  // Classified operation codes
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_ORDER   = 2'd1;
  localparam logic [OP_W-1:0] OP_SHUFFLE = 2'd2;

  typedef struct packed {
    logic               mode;
    logic [ID_BITS-1:0] entry_id;
    logic [RAND_W-1:0]  random_value;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_BITS-1:0]  served_id;
    logic                now_empty;
  } out_t;

  typedef struct packed {
    logic random_order;
    logic repeat_mode;
  } cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ID_BITS-1:0] entry_id;
    logic [RAND_W-1:0]  random_value;
  } cmd_t;

endpackage

// ===== design/shuffle_or_sequential_picker.sv =====
// Top level of the shuffle-or-sequential picker.
// A transaction is taken when start is high and busy is low; busy rises only when
// the two-entry command queue is full. Each transaction gives one result, shown for
// one cycle with out_valid, in order. The back end runs one command at a time:
// an append in S_EXEC, an order-mode serve in S_EXEC then S_ORD, and a shuffled
// serve in S_EXEC, S_SRD, S_SWR1 and S_SWR2, each then via the output register.
// The shuffled serve is shaped by the entry table, which has a single write port:
// the two swapped entries are read together in S_SRD and written back one after
// the other in S_SWR1 and S_SWR2, after the pick index is multiplied out. The
// result port cannot be stalled. The entry table needs no clearing after reset.
`include "assert_macros.svh"

module shuffle_or_sequential_picker import sosp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  output logic                 out_valid,
  output out_t                 out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;
  cfg_t cfg;

  sosp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd_in),
    .cfg       (cfg)
  );

  sosp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  sosp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_head),
    .q_pop     (q_pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Checks
  `SOSP_ASSERT_IMPLY(a_id_zero_unless_served,
                     out_valid && out_data.status != ST_SERVED, out_data.served_id == '0,
                     "served_id nonzero without a served entry")
  `SOSP_ASSERT_IMPLY(a_none_means_empty,
                     out_valid && out_data.status == ST_NONE, out_data.now_empty,
                     "nothing served but table not reported empty")
  `SOSP_ASSERT_NEVER(a_pop_from_empty, q_pop && !q_valid, "command popped from an empty queue")

endmodule

// ===== design/sosp_front.sv =====
// Front end: configuration registers and classification of accepted transactions.
module sosp_front import sosp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic                 cfg_wdata,
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_cmd,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_RANDOM_ORDER: cfg_nxt.random_order = cfg_wdata;
        REG_REPEAT_MODE:  cfg_nxt.repeat_mode  = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept while the queue has room; classify by mode and picking order
  always_comb begin
    busy   = q_full;
    q_push = start && !q_full;
    q_cmd.entry_id     = in_data.entry_id;
    q_cmd.random_value = in_data.random_value;
    if (in_data.mode == MODE_APPEND) begin
      q_cmd.op = OP_APPEND;
    end else if (cfg_r.random_order) begin
      q_cmd.op = OP_SHUFFLE;
    end else begin
      q_cmd.op = OP_ORDER;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/sosp_queue.sv =====
// Short command queue between the front end and the back end.
module sosp_queue import sosp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] fill_r;
  logic [QCNT_W-1:0] fill_nxt;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + QCNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full  = (fill_r == QCNT_W'(QUEUE_DEPTH));
  assign valid = (fill_r != '0);
  assign head  = slot_r[rd_ptr_r];

endmodule

// ===== design/sosp_back.sv =====
// Back end: entry table, counters and the append, order and shuffle sequencer.
module sosp_back import sosp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic q_pop,
  input  cfg_t cfg,
  output logic out_valid,
  output out_t out_data
);

  localparam int SW = 3;
  localparam logic [SW-1:0] S_IDLE = 3'd0;
  localparam logic [SW-1:0] S_EXEC = 3'd1;
  localparam logic [SW-1:0] S_ORD  = 3'd2;
  localparam logic [SW-1:0] S_SRD  = 3'd3;
  localparam logic [SW-1:0] S_SWR1 = 3'd4;
  localparam logic [SW-1:0] S_SWR2 = 3'd5;

  logic [ID_BITS-1:0] table_mem [TABLE_DEPTH];

  logic [SW-1:0]      state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   next_r, next_nxt;
  logic [CNT_W-1:0]   unshuf_r, unshuf_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [ID_BITS-1:0] rd_a_r, rd_b_r;
  logic               out_valid_r;
  out_t               out_data_r;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr_a, rd_addr_b;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_BITS-1:0] wr_data;
  logic               emit;
  logic [STATUS_W-1:0] status_v;
  logic [ID_BITS-1:0] served_v;
  logic               empty_v;
  logic [CNT_W-1:0]   eff_cnt;
  logic [CNT_W-1:0]   pick_raw;
  logic [CNT_W-1:0]   tail_cnt;
  logic [CNT_W-1:0]   pick_cnt;
  logic [CNT_W-1:0]   order_idx;

  // Sequence one command at a time
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    count_nxt  = count_r;
    next_nxt   = next_r;
    unshuf_nxt = unshuf_r;
    prod_nxt   = prod_r;
    pick_nxt   = pick_r;
    tail_nxt   = tail_r;
    q_pop      = 1'b0;
    rd_en      = 1'b0;
    rd_addr_a  = '0;
    rd_addr_b  = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    emit       = 1'b0;
    status_v   = ST_NONE;
    served_v   = '0;
    eff_cnt    = (unshuf_r == '0) ? count_r : unshuf_r;
    order_idx  = (next_r >= count_r) ? '0 : next_r;
    pick_raw   = prod_r[PROD_W-1 -: CNT_W];
    tail_cnt   = unshuf_r - CNT_W'(1);
    pick_cnt   = (pick_raw > tail_cnt) ? tail_cnt : pick_raw;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (cmd_r.op)
          OP_APPEND: begin
            emit = 1'b1;
            if (count_r == CNT_W'(TABLE_DEPTH)) begin
              status_v = ST_FULL;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = count_r[IDX_W-1:0];
              wr_data   = cmd_r.entry_id;
              count_nxt = count_r + CNT_W'(1);
              status_v  = ST_APPENDED;
            end
            unshuf_nxt = count_nxt;
          end
          OP_ORDER: begin
            if (count_r == '0 || (next_r >= count_r && !cfg.repeat_mode)) begin
              emit = 1'b1;
            end else begin
              rd_en     = 1'b1;
              rd_addr_a = order_idx[IDX_W-1:0];
              next_nxt  = order_idx;
              state_nxt = S_ORD;
            end
          end
          OP_SHUFFLE: begin
            if (count_r == '0 || (unshuf_r == '0 && !cfg.repeat_mode)) begin
              emit = 1'b1;
            end else begin
              unshuf_nxt = eff_cnt;
              prod_nxt   = PROD_W'(eff_cnt) * PROD_W'(cmd_r.random_value);
              state_nxt  = S_SRD;
            end
          end
          default: begin
            emit = 1'b1;
          end
        endcase
      end
      S_ORD: begin
        emit      = 1'b1;
        status_v  = ST_SERVED;
        served_v  = rd_a_r;
        next_nxt  = next_r + CNT_W'(1);
        state_nxt = S_IDLE;
      end
      S_SRD: begin
        rd_en     = 1'b1;
        rd_addr_a = pick_cnt[IDX_W-1:0];
        rd_addr_b = tail_cnt[IDX_W-1:0];
        pick_nxt  = pick_cnt[IDX_W-1:0];
        tail_nxt  = tail_cnt[IDX_W-1:0];
        state_nxt = S_SWR1;
      end
      S_SWR1: begin
        wr_en     = 1'b1;
        wr_addr   = pick_r;
        wr_data   = rd_b_r;
        state_nxt = S_SWR2;
      end
      S_SWR2: begin
        wr_en      = 1'b1;
        wr_addr    = tail_r;
        wr_data    = rd_a_r;
        unshuf_nxt = unshuf_r - CNT_W'(1);
        emit       = 1'b1;
        status_v   = ST_SERVED;
        served_v   = rd_a_r;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Emptiness as seen by the following request
  always_comb begin
    if (count_nxt == '0) begin
      empty_v = 1'b1;
    end else if (cfg.repeat_mode) begin
      empty_v = 1'b0;
    end else if (cfg.random_order) begin
      empty_v = (unshuf_nxt == '0);
    end else begin
      empty_v = (next_nxt >= count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      next_r      <= '0;
      unshuf_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_r      <= next_nxt;
      unshuf_r    <= unshuf_nxt;
      out_valid_r <= emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    prod_r <= prod_nxt;
    pick_r <= pick_nxt;
    tail_r <= tail_nxt;
    if (emit) begin
      out_data_r.status    <= status_v;
      out_data_r.served_id <= served_v;
      out_data_r.now_empty <= empty_v;
    end
  end

  // Entry table: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= table_mem[rd_addr_a];
      rd_b_r <= table_mem[rd_addr_b];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/tb_shuffle_or_sequential_picker.sv =====
// Self-checking testbench for the shuffle-or-sequential picker.
`timescale 1ns / 100ps

module tb_shuffle_or_sequential_picker;
  import sosp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_PRINTED = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic cfg_wdata = 1'b0;

  // Predicted state of the picker
  logic [ID_BITS-1:0] id_table [TABLE_DEPTH];
  logic [CNT_W-1:0] entry_total = '0;
  logic [CNT_W-1:0] order_pos = '0;
  logic [CNT_W-1:0] unpicked = '0;
  logic cfg_shuffle = 1'b0;
  logic cfg_repeat = 1'b0;

  out_t pending_results[$];
  int sender_idle_pct = 0;
  int cycle_count = 0;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_appended = 0;
  int n_full = 0;
  int n_served = 0;
  int n_none = 0;
  int n_cfg_writes = 0;

  shuffle_or_sequential_picker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Toggle the clock with a 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("FAIL shuffle_or_sequential_picker");
      $finish;
    end
  end

  // Print a mismatch line, up to a limit, and count it
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (n_errors < MAX_PRINTED)
      $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    n_errors++;
  endtask

  // Advance the predicted table state by one transaction and return its result
  function automatic out_t predict_result(in_t item);
    out_t res;
    logic [PROD_W-1:0] prod;
    logic [CNT_W-1:0] pick;
    logic [CNT_W-1:0] tail;
    logic [ID_BITS-1:0] picked;
    logic go;
    res.status = ST_NONE;
    res.served_id = '0;
    go = 1'b1;
    if (item.mode == MODE_APPEND) begin
      if (entry_total >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        id_table[entry_total[IDX_W-1:0]] = item.entry_id;
        entry_total = entry_total + CNT_W'(1);
        res.status = ST_APPENDED;
      end
      // Any append restarts the shuffle range, even a dropped one
      unpicked = entry_total;
    end else if (entry_total != 0) begin
      if (cfg_shuffle) begin
        if (unpicked == 0) begin
          if (cfg_repeat) unpicked = entry_total;
          else go = 1'b0;
        end
        if (go) begin
          prod = PROD_W'(unpicked) * PROD_W'(item.random_value);
          pick = CNT_W'(prod >> RAND_W);
          tail = unpicked - CNT_W'(1);
          if (pick > tail) pick = tail;
          // Swap the pick to the tail of the range and shrink it
          picked = id_table[pick[IDX_W-1:0]];
          id_table[pick[IDX_W-1:0]] = id_table[tail[IDX_W-1:0]];
          id_table[tail[IDX_W-1:0]] = picked;
          res.served_id = picked;
          unpicked = tail;
          res.status = ST_SERVED;
        end
      end else begin
        if (order_pos >= entry_total) begin
          if (cfg_repeat) order_pos = '0;
          else go = 1'b0;
        end
        if (go) begin
          res.served_id = id_table[order_pos[IDX_W-1:0]];
          order_pos = order_pos + CNT_W'(1);
          res.status = ST_SERVED;
        end
      end
    end

    if (entry_total == 0) res.now_empty = 1'b1;
    else if (cfg_repeat) res.now_empty = 1'b0;
    else if (cfg_shuffle) res.now_empty = (unpicked == 0);
    else res.now_empty = (order_pos >= entry_total);

    case (res.status)
      ST_APPENDED: n_appended++;
      ST_FULL:     n_full++;
      ST_SERVED:   n_served++;
      default:     n_none++;
    endcase
    return res;
  endfunction

  // Draw a random value, leaning on both ends of the range now and then
  function automatic logic [RAND_W-1:0] rand_draw();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return RAND_W'($urandom);
    endcase
  endfunction

  // Send one transaction, with an optional idle gap, and log its expected result
  task automatic send_item(input logic mode, input logic [ID_BITS-1:0] id,
                           input logic [RAND_W-1:0] rv);
    in_t item;
    item.mode = mode;
    item.entry_id = id;
    item.random_value = rv;
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    in_data <= item;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_result(item));
    n_sent++;
  endtask

  // Drain outstanding results, then write both registers
  task automatic set_config(input logic shuffle_on, input logic repeat_on);
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    cfg_we <= 1'b1;
    cfg_index <= REG_RANDOM_ORDER;
    cfg_wdata <= shuffle_on;
    @(posedge clk);
    cfg_shuffle = shuffle_on;
    cfg_index <= REG_REPEAT_MODE;
    cfg_wdata <= repeat_on;
    @(posedge clk);
    cfg_repeat = repeat_on;
    cfg_we <= 1'b0;
    n_cfg_writes += 2;
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (out_valid !== 1'b1) begin
        report_mismatch("out_valid level", 32'(1'b0), 32'(out_valid));
      end else if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", 32'(ST_NONE), 32'(out_data.status));
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(out_data.status));
        if (out_data.served_id !== want.served_id)
          report_mismatch("served_id", 32'(want.served_id), 32'(out_data.served_id));
        if (out_data.now_empty !== want.now_empty)
          report_mismatch("now_empty", 32'(want.now_empty), 32'(out_data.now_empty));
      end
    end
  end

  // Next requests on an empty table, in both modes
  task automatic test_empty_table();
    send_item(MODE_NEXT, '1, '0);
    set_config(1'b1, 1'b1);
    send_item(MODE_NEXT, '0, '1);
    set_config(1'b0, 1'b0);
  endtask

  // Walk the table in order, run past its end, then rewind in repeat mode
  task automatic test_order_walk();
    send_item(MODE_APPEND, 16'h0000, '0);
    send_item(MODE_APPEND, 16'hffff, '1);
    send_item(MODE_APPEND, 16'h1234, RAND_W'($urandom));
    repeat (4) send_item(MODE_NEXT, ID_BITS'($urandom), rand_draw());
    set_config(1'b0, 1'b1);
    send_item(MODE_NEXT, '0, '0);
  endtask

  // Shuffled picks at the range ends, exhaustion, mixed modes and refill
  task automatic test_shuffle_picks();
    set_config(1'b1, 1'b0);
    send_item(MODE_APPEND, 16'ha5a5, '0);
    send_item(MODE_NEXT, '0, '1);
    send_item(MODE_NEXT, '0, '0);
    send_item(MODE_NEXT, '0, 30'h2000_0000);
    send_item(MODE_NEXT, '0, RAND_W'($urandom));
    send_item(MODE_NEXT, '0, RAND_W'($urandom));
    // Order mode now walks the reordered table from where it stood
    set_config(1'b0, 1'b0);
    send_item(MODE_NEXT, '0, '0);
    set_config(1'b1, 1'b1);
    send_item(MODE_NEXT, '0, RAND_W'($urandom));
  endtask

  // Rounds of a few appends followed by a run of next requests, with noise
  task automatic test_random_rounds(input int n_items);
    int stop_at;
    int run_len;
    stop_at = n_sent + n_items;
    while (n_sent < stop_at) begin
      if ($urandom_range(0, 4) == 0)
        set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 2))
        send_item(MODE_APPEND, ID_BITS'($urandom), rand_draw());
      // Some runs are long enough to exhaust the round
      if ($urandom_range(0, 3) == 0) run_len = entry_total + $urandom_range(0, 2);
      else run_len = $urandom_range(1, 12);
      repeat (run_len) begin
        if ($urandom_range(0, 15) == 0)
          send_item(MODE_APPEND, ID_BITS'($urandom), rand_draw());
        else
          send_item(MODE_NEXT, ID_BITS'($urandom), rand_draw());
      end
    end
  endtask

  // Fill the table, overflow it, exhaust a full shuffle round, then repeat in order and run random rounds
  task automatic test_full_table();
    set_config(1'b0, 1'b0);
    while (entry_total < TABLE_DEPTH)
      send_item(MODE_APPEND, ID_BITS'($urandom), rand_draw());
    repeat (4) send_item(MODE_APPEND, ID_BITS'($urandom), rand_draw());
    set_config(1'b1, 1'b0);
    repeat (TABLE_DEPTH + 2) send_item(MODE_NEXT, ID_BITS'($urandom), rand_draw());
    set_config(1'b0, 1'b1);
    repeat (20) send_item(MODE_NEXT, ID_BITS'($urandom), rand_draw());
    test_random_rounds(300);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    sender_idle_pct = 35;
    test_empty_table();
    test_order_walk();
    test_shuffle_picks();
    test_random_rounds(400);

    sender_idle_pct = 69;
    test_random_rounds(400);

    sender_idle_pct = 0;
    test_full_table();

    // Drain and watch for stray results
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d transactions, checked %0d results: %0d appended, %0d full,",
             n_sent, n_checked, n_appended, n_full);
    $display("%0d served, %0d with nothing to serve; %0d register writes, %0d mismatches",
             n_served, n_none, n_cfg_writes, n_errors);
    if (n_errors == 0) begin
      $display("PASS shuffle_or_sequential_picker");
    end else begin
      $display("FAIL shuffle_or_sequential_picker");
    end
    $finish;
  end

endmodule
